// ----- src/spa_pkg.sv -----
// Shared types and constants for the slot pool allocator.
package spa_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int IDX_W = 6;
   localparam int STATUS_W = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd2;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_UPD1,
      ST_UPD2,
      ST_UPD3,
      ST_RESP
   } ctl_state_type;

   typedef struct packed {
      logic init_we;
      logic capture;
      logic rd_en;
      logic upd1;
      logic upd2;
      logic upd3;
   } ctl_cmd_type;

   typedef struct packed {
      logic init_last;
   } dp_status_type;

endpackage

// ----- src/spa_ctl.sv -----
// Sequencer for the slot pool allocator: clearing pass, lookup and link updates.
module spa_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  spa_pkg::dp_status_type st,
   output spa_pkg::ctl_cmd_type   cmd
);
   import spa_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (st.init_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: state_in = ST_UPD1;
         ST_UPD1: state_in = ST_UPD2;
         ST_UPD2: state_in = ST_UPD3;
         ST_UPD3: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_INIT: cmd.init_we = 1'b1;
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_READ: cmd.rd_en = 1'b1;
         ST_UPD1: cmd.upd1 = 1'b1;
         ST_UPD2: cmd.upd2 = 1'b1;
         ST_UPD3: cmd.upd3 = 1'b1;
         ST_RESP: rsp_valid = 1'b1;
         default: cmd = '0;
      endcase
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and result sides open together");

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_READ))
      else $error("accepted item did not start a lookup");

endmodule

// ----- src/spa_dp.sv -----
// Datapath for the slot pool allocator: heads, link memories and result registers.
module spa_dp #(
   parameter int SLOTS = spa_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  spa_pkg::ctl_cmd_type           cmd,
   output spa_pkg::dp_status_type         st,
   input  logic                          req_op,
   input  logic [spa_pkg::IDX_W-1:0]     req_slot_index,
   output logic [spa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [spa_pkg::IDX_W-1:0]     rsp_granted_slot
);
   import spa_pkg::*;

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LW = $clog2(SLOTS + 1);
   localparam int XW = IDX_W + AW;
   localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);

   logic [LW-1:0] next_link_ff [SLOTS];
   logic [LW-1:0] prev_link_ff [SLOTS];
   logic          busy_ff      [SLOTS];

   logic [LW-1:0]    free_head_ff, free_head_in;
   logic [LW-1:0]    used_head_ff, used_head_in;
   logic [AW-1:0]    init_cnt_ff;
   logic             op_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [LW-1:0]    next_rd_ff, prev_rd_ff;
   logic             busy_rd_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [IDX_W-1:0]    granted_ff, granted_in;

   logic [XW-1:0] idx_wide, tgt_wide;
   logic [AW-1:0] tgt;
   logic          in_range, ok;
   logic [LW-1:0] head_b;

   logic          next_we, prev_we, busy_we;
   logic [AW-1:0] next_wa, prev_wa, busy_wa;
   logic [LW-1:0] next_wd, prev_wd;
   logic          busy_wd;

   function automatic logic is_slot(input logic [LW-1:0] v);
      return v < NULL_LINK;
   endfunction

   function automatic logic [LW-1:0] nz(input logic [LW-1:0] v);
      return (v < NULL_LINK) ? v : NULL_LINK;
   endfunction

   assign idx_wide = XW'(idx_ff);
   assign in_range = idx_wide < XW'(SLOTS);
   assign tgt      = (op_ff == OP_ALLOC) ? free_head_ff[AW-1:0] : idx_wide[AW-1:0];
   assign tgt_wide = XW'(tgt);
   assign head_b   = (op_ff == OP_ALLOC) ? used_head_ff : free_head_ff;
   assign ok       = (op_ff == OP_ALLOC) ? is_slot(free_head_ff) : (in_range && busy_rd_ff);

   assign st.init_last = (init_cnt_ff == AW'(SLOTS - 1));

   always_comb begin
      next_we = 1'b0;
      next_wa = '0;
      next_wd = '0;
      prev_we = 1'b0;
      prev_wa = '0;
      prev_wd = '0;
      busy_we = 1'b0;
      busy_wa = '0;
      busy_wd = 1'b0;
      priority if (cmd.init_we) begin
         next_we = 1'b1;
         next_wa = init_cnt_ff;
         next_wd = LW'(init_cnt_ff) + LW'(1);
         prev_we = 1'b1;
         prev_wa = init_cnt_ff;
         prev_wd = (init_cnt_ff == '0) ? NULL_LINK : LW'(init_cnt_ff) - LW'(1);
         busy_we = 1'b1;
         busy_wa = init_cnt_ff;
         busy_wd = 1'b0;
      end else if (cmd.upd1 && ok) begin
         prev_we = is_slot(next_rd_ff);
         prev_wa = next_rd_ff[AW-1:0];
         prev_wd = nz(prev_rd_ff);
         next_we = is_slot(prev_rd_ff);
         next_wa = prev_rd_ff[AW-1:0];
         next_wd = nz(next_rd_ff);
      end else if (cmd.upd2 && ok) begin
         next_we = 1'b1;
         next_wa = tgt;
         next_wd = nz(head_b);
         prev_we = 1'b1;
         prev_wa = tgt;
         prev_wd = NULL_LINK;
      end else if (cmd.upd3 && ok) begin
         prev_we = is_slot(head_b);
         prev_wa = head_b[AW-1:0];
         prev_wd = LW'(tgt);
         busy_we = 1'b1;
         busy_wa = tgt;
         busy_wd = (op_ff == OP_ALLOC);
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) next_link_ff[next_wa] <= next_wd;
      if (prev_we) prev_link_ff[prev_wa] <= prev_wd;
      if (busy_we) busy_ff[busy_wa] <= busy_wd;
      if (cmd.rd_en) begin
         next_rd_ff <= next_link_ff[tgt];
         prev_rd_ff <= prev_link_ff[tgt];
         busy_rd_ff <= busy_ff[tgt];
      end
   end

   always_comb begin
      free_head_in = free_head_ff;
      used_head_in = used_head_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      if (cmd.upd3) begin
         if (ok) begin
            status_in  = STATUS_OK;
            granted_in = tgt_wide[IDX_W-1:0];
            if (op_ff == OP_ALLOC) begin
               if (!is_slot(prev_rd_ff)) free_head_in = nz(next_rd_ff);
               used_head_in = LW'(tgt);
            end else begin
               if (!is_slot(prev_rd_ff)) used_head_in = nz(next_rd_ff);
               free_head_in = LW'(tgt);
            end
         end else begin
            status_in  = (op_ff == OP_ALLOC) ? STATUS_NO_SPACE : STATUS_NOT_ALLOC;
            granted_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         used_head_ff <= NULL_LINK;
         init_cnt_ff  <= '0;
         status_ff    <= STATUS_OK;
         granted_ff   <= '0;
      end else begin
         free_head_ff <= free_head_in;
         used_head_ff <= used_head_in;
         status_ff    <= status_in;
         granted_ff   <= granted_in;
         if (cmd.init_we) init_cnt_ff <= init_cnt_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         idx_ff <= req_slot_index;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_granted_slot = granted_ff;

   a_heads_distinct: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff == used_head_ff) |-> (free_head_ff == NULL_LINK))
      else $error("free and in-use lists share a head");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (status_ff != STATUS_OK) |-> (granted_ff == '0))
      else $error("error result carries a slot");

endmodule

// ----- src/slot_pool_allocator_top.sv -----
// Top level of the slot pool allocator: controller and datapath.
// Keeps SLOTS slots on two doubly linked lists (free and in use) in link memories
// with one write port and registered reads. After reset a clearing pass writes one
// link entry per cycle, and no request is taken until it is done. Each request
// then goes through accept, a lookup read of the target slot's links and busy
// bit, link writes in UPD1 to UPD3 (the link memories have one write port each,
// and a request rewrites up to three prev links), and the result state, held
// until the result side is ready. One request is handled at a time.
module slot_pool_allocator_top #(
   parameter int SLOTS = spa_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [spa_pkg::IDX_W-1:0]     req_slot_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [spa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [spa_pkg::IDX_W-1:0]     rsp_granted_slot
);
   import spa_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type st;

   spa_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   spa_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_op           (req_op),
      .req_slot_index   (req_slot_index),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot)
   );

endmodule

// ----- tb/slot_pool_allocator_top_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the slot pool allocator, with a built-in free/in-use list predictor.
module slot_pool_allocator_top_test;

   localparam int NUM_SLOTS      = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_LIMIT    = 2000;
   localparam int HOLD_CYCLES    = 150;
   localparam logic [6:0] NULL_LINK = 7'd64;

   typedef struct packed {
      logic [spa_pkg::STATUS_W-1:0] status;
      logic [spa_pkg::IDX_W-1:0]    slot;
   } grant_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_op = spa_pkg::OP_ALLOC;
   logic [spa_pkg::IDX_W-1:0]     req_slot_index = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [spa_pkg::STATUS_W-1:0]  rsp_status;
   logic [spa_pkg::IDX_W-1:0]     rsp_granted_slot;

   logic [6:0] link_next [NUM_SLOTS];
   logic [6:0] link_prev [NUM_SLOTS];
   logic [6:0] free_top;
   logic [6:0] used_top;
   bit         slot_taken [NUM_SLOTS];
   int         taken_count;

   grant_type grants_due [$];
   int     mismatches = 0;
   int     items_sent = 0;
   int     stuck_cycles = 0;
   int     hold_request = 0;
   bit     quiet = 1'b0;
   int     n_grants = 0;
   int     n_releases = 0;
   int     n_full = 0;
   int     n_bad = 0;
   int     peak_taken = 0;
   int     holdoffs_done = 0;

   slot_pool_allocator_top #(.SLOTS(NUM_SLOTS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot)
   );

   always #5 clock = ~clock;

   function automatic bit is_slot(logic [6:0] v);
      return v < 7'(NUM_SLOTS);
   endfunction

   function automatic void reset_pool();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         link_next[i]  = (i < NUM_SLOTS - 1) ? 7'(i + 1) : NULL_LINK;
         link_prev[i]  = (i == 0) ? NULL_LINK : 7'(i - 1);
         slot_taken[i] = 1'b0;
      end
      free_top    = '0;
      used_top    = NULL_LINK;
      taken_count = 0;
   endfunction

   function automatic void unlink_slot(bit on_used, logic [6:0] s);
      logic [6:0] n;
      logic [6:0] p;
      n = link_next[s[5:0]];
      p = link_prev[s[5:0]];
      if (is_slot(n)) link_prev[n[5:0]] = is_slot(p) ? p : NULL_LINK;
      if (is_slot(p)) link_next[p[5:0]] = is_slot(n) ? n : NULL_LINK;
      else if (on_used) used_top = is_slot(n) ? n : NULL_LINK;
      else free_top = is_slot(n) ? n : NULL_LINK;
   endfunction

   function automatic void push_front(bit on_used, logic [6:0] s);
      logic [6:0] old;
      old = on_used ? used_top : free_top;
      link_next[s[5:0]] = is_slot(old) ? old : NULL_LINK;
      link_prev[s[5:0]] = NULL_LINK;
      if (is_slot(old)) link_prev[old[5:0]] = s;
      if (on_used) used_top = s;
      else free_top = s;
   endfunction

   function automatic grant_type predict_request(logic op, logic [5:0] idx);
      grant_type  g;
      logic [6:0] s;
      g.status = spa_pkg::STATUS_OK;
      g.slot   = '0;
      if (op == spa_pkg::OP_ALLOC) begin
         if (!is_slot(free_top)) begin
            g.status = spa_pkg::STATUS_NO_SPACE;
            n_full++;
         end else begin
            s = free_top;
            unlink_slot(1'b0, s);
            push_front(1'b1, s);
            slot_taken[s[5:0]] = 1'b1;
            taken_count++;
            if (taken_count > peak_taken) peak_taken = taken_count;
            g.slot = s[5:0];
            n_grants++;
         end
      end else begin
         if (!slot_taken[idx]) begin
            g.status = spa_pkg::STATUS_NOT_ALLOC;
            n_bad++;
         end else begin
            unlink_slot(1'b1, {1'b0, idx});
            push_front(1'b0, {1'b0, idx});
            slot_taken[idx] = 1'b0;
            taken_count--;
            g.slot = idx;
            n_releases++;
         end
      end
      return g;
   endfunction

   function automatic logic [5:0] pick_taken_slot();
      logic [5:0] held [$];
      for (int i = 0; i < NUM_SLOTS; i++)
         if (slot_taken[i]) held.push_back(6'(i));
      return held[$urandom_range(0, held.size() - 1)];
   endfunction

   function automatic void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
   endfunction

   task automatic send_item(input logic op, input logic [5:0] idx);
      int   gap;
      logic took;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_slot_index <= idx;
      do begin
         @(negedge clock);
         took = req_ready;
         if (took) grants_due.push_back(predict_request(op, idx));
         @(posedge clock);
      end while (!took);
      items_sent++;
   endtask

   task automatic send_random(input int alloc_pct);
      if ($urandom_range(0, 99) < alloc_pct)
         send_item(spa_pkg::OP_ALLOC, 6'($urandom));
      else if (taken_count > 0 && $urandom_range(0, 99) < 85)
         send_item(spa_pkg::OP_FREE, pick_taken_slot());
      else
         send_item(spa_pkg::OP_FREE, 6'($urandom));
   endtask

   task automatic test_directed_basics();
      send_item(spa_pkg::OP_ALLOC, 6'd63);
      send_item(spa_pkg::OP_ALLOC, 6'd0);
      send_item(spa_pkg::OP_ALLOC, 6'd42);
      send_item(spa_pkg::OP_FREE, 6'd63);
      send_item(spa_pkg::OP_FREE, 6'd1);
      send_item(spa_pkg::OP_FREE, 6'd1);
      send_item(spa_pkg::OP_FREE, 6'd2);
      send_item(spa_pkg::OP_FREE, 6'd0);
      send_item(spa_pkg::OP_FREE, 6'd0);
      send_item(spa_pkg::OP_ALLOC, 6'd21);
      send_item(spa_pkg::OP_ALLOC, 6'd0);
      send_item(spa_pkg::OP_ALLOC, 6'd63);
      send_item(spa_pkg::OP_ALLOC, 6'd12);
      send_item(spa_pkg::OP_FREE, 6'd3);
      send_item(spa_pkg::OP_FREE, 6'd0);
      send_item(spa_pkg::OP_FREE, 6'd2);
      send_item(spa_pkg::OP_FREE, 6'd1);
      send_item(spa_pkg::OP_FREE, 6'd32);
   endtask

   task automatic test_pool_exhaustion();
      logic [5:0] victim;
      while (taken_count < NUM_SLOTS) send_item(spa_pkg::OP_ALLOC, 6'($urandom));
      repeat (3) send_item(spa_pkg::OP_ALLOC, 6'($urandom));
      victim = pick_taken_slot();
      send_item(spa_pkg::OP_FREE, victim);
      send_item(spa_pkg::OP_FREE, victim);
      send_item(spa_pkg::OP_ALLOC, 6'($urandom));
      send_item(spa_pkg::OP_ALLOC, 6'($urandom));
   endtask

   task automatic test_drain_pool();
      while (taken_count > 0) send_item(spa_pkg::OP_FREE, pick_taken_slot());
      send_item(spa_pkg::OP_FREE, 6'($urandom));
   endtask

   task automatic test_back_to_back();
      quiet = 1'b1;
      repeat (150) send_random(55);
      quiet = 1'b0;
   endtask

   task automatic test_receiver_holdoff();
      hold_request = HOLD_CYCLES;
      repeat (12) send_random(60);
   endtask

   task automatic test_random_traffic();
      int bias;
      repeat (13) begin
         case ($urandom_range(0, 4))
            0: bias = 95;
            1: bias = 70;
            2: bias = 50;
            3: bias = 30;
            default: bias = 5;
         endcase
         repeat (100) send_random(bias);
      end
   endtask

   initial begin
      int   stall;
      logic got;
      @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 3);
         if (hold_request != 0) begin
            stall = hold_request;
            hold_request = 0;
            holdoffs_done++;
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(negedge clock);
            got = rsp_valid;
            @(posedge clock);
         end while (!got);
      end
   end

   always @(negedge clock) begin
      grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (grants_due.size() == 0) begin
            note_mismatch($sformatf("unexpected result status %0d slot %0d",
                                    rsp_status, rsp_granted_slot));
         end else begin
            want = grants_due.pop_front();
            if (rsp_status !== want.status)
               note_mismatch($sformatf("status expected %0d got %0d",
                                       want.status, rsp_status));
            if (rsp_granted_slot !== want.slot)
               note_mismatch($sformatf("granted_slot expected %0d got %0d",
                                       want.slot, rsp_granted_slot));
         end
      end
   end

   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int waited;
      reset_pool();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_pool_exhaustion();
      test_drain_pool();
      test_back_to_back();
      test_receiver_holdoff();
      test_random_traffic();
      test_pool_exhaustion();
      test_drain_pool();
      req_valid <= 1'b0;
      waited = 0;
      while (grants_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (12) @(posedge clock);
      if (grants_due.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", grants_due.size()));
      $display("Sent %0d requests: %0d grants, %0d releases, %0d refused on a full pool,",
               items_sent, n_grants, n_releases, n_full);
      $display("%0d frees of idle slots, peak occupancy %0d, %0d long output stalls;",
               n_bad, peak_taken, holdoffs_done);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- slot_pool_allocator_top.f -----
src/spa_pkg.sv
src/spa_ctl.sv
src/spa_dp.sv
src/slot_pool_allocator_top.sv
tb/slot_pool_allocator_top_test.sv
